/* rtl/hadamard_delay_diffuser_assert.svh */
// Assertion macros shared by the diffuser RTL.
// Needs nothing else; files that check their own logic include it.
`ifndef HADAMARD_DELAY_DIFFUSER_ASSERT_SVH
`define HADAMARD_DELAY_DIFFUSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HDD_ASSERT_IMPLY(name, clk_s, rst_s, pre, post) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error("diffuser check failed");

// Next-cycle implication, disabled while reset is high.
`define HDD_ASSERT_NEXT(name, clk_s, rst_s, pre, post) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error("diffuser check failed");

`endif

/* rtl/hdd_pkg.sv */
// Package for the Hadamard delay diffuser: widths, sample types, register codes,
// lane result struct and the saturation and delay reduction helpers. No dependencies.
`default_nettype none

package hdd_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 1024;
  localparam int unsigned CHANNELS       = 4;
  localparam int unsigned SAMPLE_W       = 18;
  localparam int unsigned Q15_W          = 16;
  localparam int unsigned MIX_W          = 17;
  localparam int unsigned ACC_W          = 18;
  localparam int unsigned DELAY_W        = 10;
  localparam int unsigned REG_IDX_W      = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [Q15_W-1:0]    q15_t;
  typedef logic signed [MIX_W-1:0]    mix_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [DELAY_W-1:0]         delay_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DELAY_CH0,
    REG_DELAY_CH1,
    REG_DELAY_CH2,
    REG_DELAY_CH3
  } reg_index_t;

  // What one lane hands to the mixing stage.
  typedef struct packed {
    q15_t tap;
    logic clip;
  } lane_res_t;

  localparam sample_t SAT_HI  = sample_t'(32767);
  localparam sample_t SAT_LO  = sample_t'(-32768);
  localparam q15_t    Q15_MAX = q15_t'(32767);
  localparam q15_t    Q15_MIN = q15_t'(-32768);

  // Reduces a delay modulo the line depth by restoring subtraction.
  // With a constant depth, only the steps where the shifted depth can fit survive.
  function automatic delay_t reduce_delay(input delay_t d, input int unsigned depth);
    logic [31:0] r;
    r = 32'(d);
    for (int k = DELAY_W - 1; k >= 0; k--) begin
      if (r >= (32'(depth) << k)) begin
        r = r - (32'(depth) << k);
      end
    end
    return r[DELAY_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/hdd_if.sv */
// Valid/ready channel interfaces for the diffuser: four input samples per item,
// four mixed outputs plus the clip flag per result item. Depends on hdd_pkg.
`default_nettype none

interface hdd_in_if;
  logic             valid;
  logic             ready;
  hdd_pkg::sample_t in_ch0;
  hdd_pkg::sample_t in_ch1;
  hdd_pkg::sample_t in_ch2;
  hdd_pkg::sample_t in_ch3;

  modport source (output valid, output in_ch0, output in_ch1, output in_ch2,
                  output in_ch3, input ready);
  modport sink   (input valid, input in_ch0, input in_ch1, input in_ch2,
                  input in_ch3, output ready);
endinterface

interface hdd_out_if;
  logic          valid;
  logic          ready;
  hdd_pkg::mix_t out_ch0;
  hdd_pkg::mix_t out_ch1;
  hdd_pkg::mix_t out_ch2;
  hdd_pkg::mix_t out_ch3;
  logic          clip_flag;

  modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
                  output out_ch3, output clip_flag, input ready);
  modport sink   (input valid, input out_ch0, input out_ch1, input out_ch2,
                  input out_ch3, input clip_flag, output ready);
endinterface

`default_nettype wire

/* rtl/hadamard_delay_diffuser.sv */
// An accepted item is registered in the lane tap stage, then in the merge output register;
// while the output register holds an untaken result, the tap stage waits behind it.
// Throughput: one item per cycle if unstalled; each lane writes and reads its dual-port line once.
// Reset (rst, synchronous, active high) clears the write index, the fill count,
// the delay registers and both valid flags. The delay lines get no clearing pass:
// taps older than the items seen since reset read as zero through the fill count.
// Top level: config registers, shared write index, handshake, four lanes, merge stage.
// Depends on hdd_pkg, hdd_if, hdd_lane, hdd_merge and the assertion macro header.
`default_nettype none
`include "hadamard_delay_diffuser_assert.svh"

module hadamard_delay_diffuser #(
  parameter int unsigned LINE_DEPTH = hdd_pkg::LINE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  hdd_pkg::reg_index_t cfg_index,
  input  hdd_pkg::delay_t     cfg_data,
  hdd_in_if.sink              in_item,
  hdd_out_if.source           out_item
);
  import hdd_pkg::*;

  localparam int unsigned     ADDR_W    = $clog2(LINE_DEPTH);
  localparam int unsigned     FILL_W    = $clog2(LINE_DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(LINE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LINE_DEPTH);

  // Delay registers hold the value already reduced modulo the line depth, so
  // the per-item path only does one wrap-around subtract per lane.
  logic [ADDR_W-1:0] delay_q [CHANNELS];

  // Shared write position and the number of items seen since reset, which
  // saturates at the depth once every entry of every line has been written.
  logic [ADDR_W-1:0] wr_idx;
  logic [FILL_W-1:0] fill;

  // The lanes register their tap at acceptance; a_valid marks that stage full.
  logic      a_valid;
  logic      a_adv;
  logic      in_acc;
  logic      merge_free;
  sample_t   smp [CHANNELS];
  lane_res_t lane_res [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        delay_q[c] <= '0;
      end
    end else if (cfg_we) begin
      delay_q[cfg_index] <= ADDR_W'(reduce_delay(cfg_data, LINE_DEPTH));
    end
  end

  // The tap stage moves into the output register whenever that register is free,
  // and a new item may enter in the same cycle, so items flow at one per clock while it stays free.
  assign a_adv         = a_valid && merge_free;
  assign in_item.ready = !a_valid || merge_free;
  assign in_acc        = in_item.valid && in_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      fill   <= '0;
    end else if (in_acc) begin
      wr_idx <= (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
      if (fill != FILL_FULL) begin
        fill <= fill + 1'b1;
      end
    end
  end

  assign smp[0] = in_item.in_ch0;
  assign smp[1] = in_item.in_ch1;
  assign smp[2] = in_item.in_ch2;
  assign smp[3] = in_item.in_ch3;

  // Each lane writes its saturated sample at wr_idx and reads its own tap in
  // the same cycle; the merge stage combines the four taps.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    hdd_lane #(
      .LINE_DEPTH(LINE_DEPTH)
    ) u_lane (
      .clk    (clk),
      .load   (in_acc),
      .sample (smp[c]),
      .wr_addr(wr_idx),
      .delay  (delay_q[c]),
      .fill   (fill),
      .res    (lane_res[c])
    );
  end

  hdd_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .load    (a_adv),
    .res     (lane_res),
    .free    (merge_free),
    .out_item(out_item)
  );

  // Every accepted item lands in the tap stage.
  `HDD_ASSERT_NEXT(a_acc_fills_stage, clk, rst, in_acc, a_valid)
  // A tap that cannot move on is kept, not dropped.
  `HDD_ASSERT_NEXT(a_stage_holds, clk, rst, a_valid && !a_adv, a_valid)
  // The write position steps by one per item and wraps at the line end.
  `HDD_ASSERT_NEXT(a_idx_step, clk, rst, in_acc,
    wr_idx == (($past(wr_idx) == LAST_IDX) ? '0 : ADDR_W'($past(wr_idx) + 1'b1)))
  // Until the lines are full, the write position equals the fill count.
  `HDD_ASSERT_IMPLY(a_idx_fill, clk, rst, fill != FILL_FULL, wr_idx == ADDR_W'(fill))

endmodule

`default_nettype wire

/* rtl/hdd_lane.sv */
// One diffuser lane: saturation, a private circular delay memory and the tap read.
// Depends on hdd_pkg.
`default_nettype none

module hdd_lane #(
  parameter int unsigned LINE_DEPTH = hdd_pkg::LINE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              load,
  input  hdd_pkg::sample_t                  sample,
  input  logic [$clog2(LINE_DEPTH)-1:0]     wr_addr,
  input  logic [$clog2(LINE_DEPTH)-1:0]     delay,
  input  logic [$clog2(LINE_DEPTH + 1)-1:0] fill,
  output hdd_pkg::lane_res_t                res
);
  import hdd_pkg::*;

  localparam int unsigned ADDR_W = $clog2(LINE_DEPTH);
  localparam int unsigned FILL_W = $clog2(LINE_DEPTH + 1);

  q15_t              mem [LINE_DEPTH];
  q15_t              wdata;
  q15_t              rdata;
  q15_t              wdata_q;
  logic              clip;
  logic              clip_q;
  logic              bypass_q;
  logic              live_q;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    clip = (sample > SAT_HI) || (sample < SAT_LO);
    priority if (sample > SAT_HI) begin
      wdata = Q15_MAX;
    end else if (sample < SAT_LO) begin
      wdata = Q15_MIN;
    end else begin
      wdata = q15_t'(sample[Q15_W-1:0]);
    end
  end

  // Both operands are below the depth, so one conditional wrap is enough.
  always_comb begin
    if (wr_addr >= delay) begin
      rd_addr = wr_addr - delay;
    end else begin
      rd_addr = wr_addr - delay + ADDR_W'(LINE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mem[wr_addr] <= wdata;
      rdata        <= mem[rd_addr];
    end
  end

  // A zero delay takes the sample written by the same item. A tap older than
  // the number of items seen since reset reads as zero.
  always_ff @(posedge clk) begin
    if (load) begin
      wdata_q  <= wdata;
      clip_q   <= clip;
      bypass_q <= (delay == '0);
      live_q   <= (FILL_W'(delay) <= fill);
    end
  end

  always_comb begin
    res.clip = clip_q;
    if (bypass_q) begin
      res.tap = wdata_q;
    end else if (live_q) begin
      res.tap = rdata;
    end else begin
      res.tap = '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/hdd_merge.sv */
// Mixing stage: 4-point Hadamard butterfly over the lane taps, halving with
// floor rounding, and the output register. Depends on hdd_pkg and hdd_if.
`default_nettype none

module hdd_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  hdd_pkg::lane_res_t res [hdd_pkg::CHANNELS],
  output logic               free,
  hdd_out_if.source          out_item
);
  import hdd_pkg::*;

  mix_t d [CHANNELS];
  mix_t sum_a;
  mix_t sum_b;
  mix_t dif_a;
  mix_t dif_b;
  acc_t mix0;
  acc_t mix1;
  acc_t mix2;
  acc_t mix3;
  logic clip_any;

  logic out_valid;
  mix_t out0;
  mix_t out1;
  mix_t out2;
  mix_t out3;
  logic out_clip;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      d[c] = MIX_W'(res[c].tap);
    end
    sum_a    = d[0] + d[1];
    sum_b    = d[2] + d[3];
    dif_a    = d[0] - d[1];
    dif_b    = d[2] - d[3];
    mix0     = ACC_W'(sum_a) + ACC_W'(sum_b);
    mix1     = ACC_W'(dif_a) + ACC_W'(dif_b);
    mix2     = ACC_W'(sum_a) - ACC_W'(sum_b);
    mix3     = ACC_W'(dif_a) - ACC_W'(dif_b);
    clip_any = res[0].clip | res[1].clip | res[2].clip | res[3].clip;
  end

  assign free = !out_valid || out_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Dropping the low bit of the sum is an arithmetic halving, rounded down.
  always_ff @(posedge clk) begin
    if (load) begin
      out0     <= mix0[ACC_W-1:1];
      out1     <= mix1[ACC_W-1:1];
      out2     <= mix2[ACC_W-1:1];
      out3     <= mix3[ACC_W-1:1];
      out_clip <= clip_any;
    end
  end

  assign out_item.valid     = out_valid;
  assign out_item.out_ch0   = out0;
  assign out_item.out_ch1   = out1;
  assign out_item.out_ch2   = out2;
  assign out_item.out_ch3   = out3;
  assign out_item.clip_flag = out_clip;

endmodule

`default_nettype wire
